@@ design/pts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the periodic task slot scheduler.
// No dependencies; every other file of the block uses this package.
package pts_pkg;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_ADDED    = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_DELETED  = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_TICK     = 3'd4,
    STAT_DUE      = 3'd5,
    STAT_NONE     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  // Most task transactions one dispatch may emit.
  localparam int MAX_RESULTS = 8;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] PENDING_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] delay;
    logic [31:0] period;
    logic [15:0] pending;
  } slot_entry_t;

  typedef struct packed {
    logic [15:0] due_id;
    status_e     status;
    logic        retired;
    logic        last;
  } result_t;

endpackage

@@ design/pts_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and results.
// Depends on pts_pkg for the command and status codes.
interface pts_in_if;
  logic            valid;
  logic            ready;
  pts_pkg::cmd_e   cmd;
  logic [15:0]     task_id;
  logic [31:0]     start_delay;
  logic [31:0]     run_period;

  modport source (output valid, cmd, task_id, start_delay, run_period, input ready);
  modport sink   (input valid, cmd, task_id, start_delay, run_period, output ready);
endinterface

interface pts_out_if;
  logic             valid;
  logic             ready;
  logic [15:0]      due_id;
  pts_pkg::status_e status;
  logic             retired;
  logic             last;

  modport source (output valid, due_id, status, retired, last, input ready);
  modport sink   (input valid, due_id, status, retired, last, output ready);
endinterface

@@ design/pts_slot_ram.sv @@
`timescale 1ns / 1ps
// Slot table memory: one write port and one read port, registered read data.
// Depends on pts_pkg for the slot entry layout.
module pts_slot_ram #(
  parameter int SLOTS = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  input  pts_pkg::slot_entry_t                   wr_data,
  input  logic                                   rd_en,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  output pts_pkg::slot_entry_t                   rd_data
);
  import pts_pkg::*;

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/pts_out_stage.sv @@
`timescale 1ns / 1ps
// Result output register that decouples the engine from the result channel.
// Depends on pts_pkg and pts_if.
module pts_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  pts_pkg::result_t   push_res,
  output logic               out_free,
  pts_out_if.source          out_if
);
  import pts_pkg::*;

  logic    out_v_r;
  result_t out_res_r;

  assign out_free = !out_v_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push_valid) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      out_res_r <= push_res;
    end
  end

  assign out_if.valid   = out_v_r;
  assign out_if.due_id  = out_res_r.due_id;
  assign out_if.status  = out_res_r.status;
  assign out_if.retired = out_res_r.retired;
  assign out_if.last    = out_res_r.last;

endmodule

@@ design/pts_engine.sv @@
`timescale 1ns / 1ps
// Command sequencer: walks the slot memory with read-modify-write and
// keeps the occupancy bits. Depends on pts_pkg.
module pts_engine #(
  parameter int SLOTS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  pts_pkg::cmd_e                          in_cmd,
  input  logic [15:0]                            in_task_id,
  input  logic [31:0]                            in_start_delay,
  input  logic [31:0]                            in_run_period,
  output logic                                   wr_en,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  output pts_pkg::slot_entry_t                   wr_data,
  output logic                                   rd_en,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  input  pts_pkg::slot_entry_t                   rd_data,
  output logic                                   push_valid,
  output pts_pkg::result_t                       push_res,
  input  logic                                   out_free
);
  import pts_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_e               state_r, state_nxt;
  logic [SLOTS-1:0]     used_r, used_nxt;
  cmd_e                 cmd_r, cmd_nxt;
  logic [15:0]          id_r, id_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 p_valid_r, p_valid_nxt;
  logic [IDX_W-1:0]     p_idx_r, p_idx_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 hold_v_r, hold_v_nxt;
  result_t              hold_r, hold_nxt;

  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;

  // First free slot, lowest index wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      used_r    <= '0;
      p_valid_r <= 1'b0;
      hold_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      p_valid_r <= p_valid_nxt;
      hold_v_r  <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    id_r     <= id_nxt;
    rd_idx_r <= rd_idx_nxt;
    p_idx_r  <= p_idx_nxt;
    cnt_r    <= cnt_nxt;
    hold_r   <= hold_nxt;
  end

  always_comb begin
    logic stall;
    logic done;
    logic retire;

    stall       = 1'b0;
    done        = 1'b0;
    retire      = 1'b0;
    state_nxt   = state_r;
    used_nxt    = used_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    rd_idx_nxt  = rd_idx_r;
    p_valid_nxt = 1'b0;
    p_idx_nxt   = p_idx_r;
    cnt_nxt     = cnt_r;
    hold_v_nxt  = hold_v_r;
    hold_nxt    = hold_r;
    in_ready    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = p_idx_r;
    wr_data     = rd_data;
    rd_en       = 1'b0;
    rd_addr     = rd_idx_r[IDX_W-1:0];
    push_valid  = 1'b0;
    push_res    = hold_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          id_nxt     = in_task_id;
          rd_idx_nxt = '0;
          cnt_nxt    = '0;
          hold_v_nxt = 1'b0;
          if (in_cmd == CMD_ADD) begin
            hold_v_nxt       = 1'b1;
            hold_nxt.due_id  = in_task_id;
            hold_nxt.status  = free_found ? STAT_ADDED : STAT_FULL;
            hold_nxt.retired = 1'b0;
            hold_nxt.last    = 1'b1;
            if (free_found) begin
              wr_en              = 1'b1;
              wr_addr            = free_idx;
              wr_data.id         = in_task_id;
              wr_data.delay      = in_start_delay;
              wr_data.period     = in_run_period;
              wr_data.pending    = '0;
              used_nxt[free_idx] = 1'b1;
            end
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (p_valid_r) begin
          case (cmd_r)
            CMD_DELETE: begin
              if (used_r[p_idx_r] && rd_data.id == id_r) begin
                used_nxt[p_idx_r] = 1'b0;
                hold_v_nxt        = 1'b1;
                hold_nxt.due_id   = id_r;
                hold_nxt.status   = STAT_DELETED;
                hold_nxt.retired  = 1'b0;
                hold_nxt.last     = 1'b1;
                done              = 1'b1;
              end
            end
            CMD_TICK: begin
              if (used_r[p_idx_r]) begin
                wr_en = 1'b1;
                if (rd_data.delay == '0) begin
                  wr_data.delay = rd_data.period;
                  if (rd_data.pending != PENDING_MAX) begin
                    wr_data.pending = rd_data.pending + 16'd1;
                  end
                end else begin
                  wr_data.delay = rd_data.delay - 32'd1;
                end
              end
            end
            CMD_DISPATCH: begin
              if (used_r[p_idx_r] && rd_data.pending != '0) begin
                if (hold_v_r && !out_free) begin
                  stall = 1'b1;
                end else begin
                  wr_en           = 1'b1;
                  wr_data.pending = rd_data.pending - 16'd1;
                  retire          = (rd_data.period == '0);
                  if (retire) begin
                    used_nxt[p_idx_r] = 1'b0;
                  end
                  // A task found behind the held one means the held one is not last.
                  if (hold_v_r) begin
                    push_valid    = 1'b1;
                    push_res.last = 1'b0;
                  end
                  hold_v_nxt       = 1'b1;
                  hold_nxt.due_id  = rd_data.id;
                  hold_nxt.status  = STAT_DUE;
                  hold_nxt.retired = retire;
                  hold_nxt.last    = 1'b1;
                  cnt_nxt          = cnt_r + RES_CNT_W'(1);
                  if (cnt_r == RES_CNT_W'(MAX_RESULTS - 1)) begin
                    done = 1'b1;
                  end
                end
              end
            end
            default: ;
          endcase
          if (!stall && p_idx_r == LAST_IDX) begin
            done = 1'b1;
          end
        end

        if (done) begin
          state_nxt = ST_FLUSH;
          if (!hold_v_nxt) begin
            hold_v_nxt       = 1'b1;
            hold_nxt.retired = 1'b0;
            hold_nxt.last    = 1'b1;
            case (cmd_r)
              CMD_DELETE: begin
                hold_nxt.due_id = id_r;
                hold_nxt.status = STAT_NOTFOUND;
              end
              CMD_TICK: begin
                hold_nxt.due_id = '0;
                hold_nxt.status = STAT_TICK;
              end
              default: begin
                hold_nxt.due_id = '0;
                hold_nxt.status = STAT_NONE;
              end
            endcase
          end
        end else if (stall) begin
          p_valid_nxt = 1'b1;
        end else if (rd_idx_r < CNT_W'(SLOTS)) begin
          rd_en       = 1'b1;
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          p_valid_nxt = 1'b1;
          p_idx_nxt   = rd_idx_r[IDX_W-1:0];
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          push_valid = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/periodic_task_slot_scheduler_core.sv @@
`timescale 1ns / 1ps
// Top level of the periodic task slot scheduler.
// Depends on pts_pkg, pts_if, pts_slot_ram, pts_out_stage and pts_engine.

// The scheduler keeps a table of SLOTS task slots and executes one command
// transaction at a time: add, delete, tick or dispatch. Slot contents (task id,
// delay, period, pending-run count) live in a single-port-write, registered-read
// memory, while the occupancy bits sit in flip-flops cleared by reset, so no
// clearing pass is needed after reset. An add finds the free slot from the
// occupancy bits and writes it directly. Delete, tick and dispatch walk the
// memory as a read-modify-write pipeline, one slot per cycle unless stalled;
// a delete stops early at its first match and a dispatch stops once it has
// produced eight tasks. The memory's single read port sets this per-slot pace.
// A dispatch also pauses its walk whenever the result channel is back-pressured
// while a due task waits to go out. Each command yields one result transaction,
// except a dispatch, which yields one per due task with last set on the final
// one. A finished result waits in an output register, so the next command is
// taken while it is still unclaimed.
module periodic_task_slot_scheduler_core #(
  parameter int SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  pts_in_if.sink     in_if,
  pts_out_if.source  out_if
);
  import pts_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  slot_entry_t       wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  slot_entry_t       rd_data;
  logic              push_valid;
  result_t           push_res;
  logic              out_free;

  // Command sequencer and occupancy bits.
  pts_engine #(
    .SLOTS (SLOTS)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .in_ready       (in_if.ready),
    .in_cmd         (in_if.cmd),
    .in_task_id     (in_if.task_id),
    .in_start_delay (in_if.start_delay),
    .in_run_period  (in_if.run_period),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .push_valid     (push_valid),
    .push_res       (push_res),
    .out_free       (out_free)
  );

  // Slot table storage.
  pts_slot_ram #(
    .SLOTS (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result register toward the consumer.
  pts_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_res   (push_res),
    .out_free   (out_free),
    .out_if     (out_if)
  );

endmodule

@@ verif/pts_sched_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the periodic task slot scheduler: predicts and checks every result.
// Depends on pts_pkg for the codes and the result type, and on pts_if for the channels.
module pts_sched_checker #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  pts_in_if           in_mon,
  pts_out_if          out_mon,
  output int unsigned mismatch_count,
  output int unsigned results_awaited
);
  import pts_pkg::*;

  // Shadow copy of the slot table.
  bit          slot_busy   [SLOTS];
  logic [15:0] slot_task   [SLOTS];
  logic [31:0] slot_wait   [SLOTS];
  logic [31:0] slot_reload [SLOTS];
  logic [15:0] slot_runs   [SLOTS];

  result_t     expected_results[$];
  int unsigned results_seen;

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    $display("[%0t] result %0d %s: expected 0x%0h, got 0x%0h",
             $time, results_seen, what, want_v, got_v);
    mismatch_count++;
  endtask

  // Applies one command transaction to the shadow table and queues its results.
  function automatic void schedule_command(input cmd_e op, input logic [15:0] id,
                                           input logic [31:0] dly, input logic [31:0] per);
    result_t batch[$];
    result_t r;
    bit      done;
    int      emitted;
    r.due_id  = id;
    r.retired = 1'b0;
    r.last    = 1'b0;
    done      = 1'b0;
    emitted   = 0;
    case (op)
      CMD_ADD: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!done && !slot_busy[s]) begin
            slot_busy[s]   = 1'b1;
            slot_task[s]   = id;
            slot_wait[s]   = dly;
            slot_reload[s] = per;
            slot_runs[s]   = '0;
            done           = 1'b1;
          end
        end
        r.status = done ? STAT_ADDED : STAT_FULL;
        batch.push_back(r);
      end
      CMD_DELETE: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!done && slot_busy[s] && slot_task[s] == id) begin
            slot_busy[s] = 1'b0;
            done         = 1'b1;
          end
        end
        r.status = done ? STAT_DELETED : STAT_NOTFOUND;
        batch.push_back(r);
      end
      CMD_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_busy[s]) begin
            if (slot_wait[s] == '0) begin
              slot_wait[s] = slot_reload[s];
              if (slot_runs[s] != PENDING_MAX) slot_runs[s]++;
            end else begin
              slot_wait[s]--;
            end
          end
        end
        r.due_id = '0;
        r.status = STAT_TICK;
        batch.push_back(r);
      end
      default: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (emitted < MAX_RESULTS && slot_busy[s] && slot_runs[s] != '0) begin
            slot_runs[s]--;
            r.retired = 1'b0;
            // A one-shot task leaves the table on its first dispatch.
            if (slot_reload[s] == '0) begin
              slot_busy[s] = 1'b0;
              r.retired    = 1'b1;
            end
            r.due_id = slot_task[s];
            r.status = STAT_DUE;
            batch.push_back(r);
            emitted++;
          end
        end
        if (emitted == 0) begin
          r.due_id = '0;
          r.status = STAT_NONE;
          batch.push_back(r);
        end
      end
    endcase
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) expected_results.push_back(batch[k]);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) slot_busy[s] = 1'b0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.due_id  = out_mon.due_id;
        got.status  = out_mon.status;
        got.retired = out_mon.retired;
        got.last    = out_mon.last;
        if (expected_results.size() == 0) begin
          report_mismatch("arrived with nothing awaited, due_id", '0, got.due_id);
        end else begin
          want = expected_results.pop_front();
          if (got.due_id !== want.due_id)
            report_mismatch("due_id", want.due_id, got.due_id);
          if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
          if (got.retired !== want.retired)
            report_mismatch("retired", want.retired, got.retired);
          if (got.last !== want.last)
            report_mismatch("last", want.last, got.last);
        end
        results_seen++;
      end
      if (in_mon.valid && in_mon.ready)
        schedule_command(in_mon.cmd, in_mon.task_id, in_mon.start_delay, in_mon.run_period);
    end
    results_awaited = expected_results.size();
  end

endmodule

@@ verif/tb_periodic_task_slot_scheduler_core.sv @@
`timescale 1ns / 1ps
// Testbench top of the periodic task slot scheduler: stimulus, flow control and verdict.
// Depends on pts_pkg, pts_if, the scheduler core and the pts_sched_checker scoreboard.
module tb_periodic_task_slot_scheduler_core;
  import pts_pkg::*;

  localparam int          SLOTS          = 8;
  // A walk over the table plus pipeline slack; used for the final quiet period.
  localparam int          DRAIN_CYCLES   = SLOTS + 8;
  // About 120 transactions finish well inside this limit, even with full
  // dispatch bursts under the heaviest stalls.
  localparam int unsigned CYCLE_LIMIT    = 200_000;
  localparam int          RANDOM_ITEMS   = 32;

  logic        clk;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned results_awaited;
  int unsigned cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  // Every id ever offered to an add; feeds deletes and duplicate adds.
  logic [15:0] added_ids[$];

  pts_in_if  in_ch ();
  pts_out_if out_ch ();

  periodic_task_slot_scheduler_core #(.SLOTS(SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  pts_sched_checker #(.SLOTS(SLOTS)) sched_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatch_count  (mismatch_count),
    .results_awaited (results_awaited)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The result side stalls at random with the current probability. A fresh
  // draw every cycle scatters stalls over every stage of a dispatch burst.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one command transaction, after a random number of idle cycles, and
  // returns at the clock edge at which the block takes it. valid is written
  // once per edge, so back-to-back transactions keep it high throughout.
  task automatic issue_command(input cmd_e op, input logic [15:0] id,
                               input logic [31:0] dly, input logic [31:0] per);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= op;
    in_ch.task_id     <= id;
    in_ch.start_delay <= dly;
    in_ch.run_period  <= per;
    if (op == CMD_ADD) added_ids.push_back(id);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Ids mostly come from those already added, so that deletes hit and
  // duplicates appear; the rest are fully random and usually miss.
  function automatic logic [15:0] pick_task_id();
    if (added_ids.size() != 0 && $urandom_range(9) < 7)
      return added_ids[$urandom_range(added_ids.size() - 1)];
    return 16'($urandom);
  endfunction

  // Random mix. Short delays and periods keep tasks falling due, so dispatches
  // emit bursts; occasional huge values park a task and help fill the table.
  task automatic run_random_phase(input int count);
    cmd_e        op;
    logic [15:0] id;
    logic [31:0] dly;
    logic [31:0] per;
    int          roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 30)      op = CMD_ADD;
      else if (roll < 50) op = CMD_DELETE;
      else if (roll < 78) op = CMD_TICK;
      else                op = CMD_DISPATCH;
      id   = pick_task_id();
      roll = $urandom_range(9);
      if (roll < 7)       dly = $urandom_range(3);
      else if (roll == 7) dly = 32'hFFFF_FFFF;
      else                dly = $urandom;
      roll = $urandom_range(9);
      if (roll < 3)       per = '0;
      else if (roll < 8)  per = $urandom_range(4, 1);
      else if (roll == 8) per = $urandom;
      else                per = 32'hFFFF_FFFF;
      issue_command(op, id, dly, per);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_TICK;
    in_ch.task_id     = '0;
    in_ch.start_delay = '0;
    in_ch.run_period  = '0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 27;
    recv_idle_pct     = 83;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, on an empty table first: nothing to dispatch, an empty
    // tick and a delete that finds nothing.
    issue_command(CMD_DISPATCH, 16'h0000, 32'h0, 32'h0);
    issue_command(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_command(CMD_DELETE, 16'h1234, 32'h0, 32'h0);
    // A one-shot due at once, a task at the field extremes and two tasks
    // sharing one id.
    issue_command(CMD_ADD, 16'h0000, 32'h0, 32'h0);
    issue_command(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_command(CMD_ADD, 16'h00A5, 32'h1, 32'h2);
    issue_command(CMD_ADD, 16'h00A5, 32'h0, 32'h1);
    // Three ticks leave the one-shot with several runs pending; the dispatch
    // must still retire it and drop the remaining runs.
    repeat (3) issue_command(CMD_TICK, 16'h0000, 32'h0, 32'h0);
    issue_command(CMD_DISPATCH, 16'h0000, 32'h0, 32'h0);
    // Fill every free slot, then add once more to a full table.
    issue_command(CMD_ADD, 16'h5A5A, 32'h2, 32'h3);
    issue_command(CMD_ADD, 16'h1111, 32'h0, 32'h0);
    issue_command(CMD_ADD, 16'h2222, 32'h1, 32'h1);
    issue_command(CMD_ADD, 16'h3333, 32'h0, 32'h2);
    issue_command(CMD_ADD, 16'h7777, 32'h3, 32'h1);
    issue_command(CMD_ADD, 16'hBEEF, 32'h0, 32'h0);
    // Duplicate ids go lowest slot first; the third delete finds nothing.
    repeat (3) issue_command(CMD_DELETE, 16'h00A5, 32'h0, 32'h0);
    issue_command(CMD_TICK, 16'h0000, 32'h0, 32'h0);
    issue_command(CMD_DISPATCH, 16'h0000, 32'h0, 32'h0);

    // Random part in three flow-control regimes.
    run_random_phase(RANDOM_ITEMS);
    send_idle_pct = 83;
    recv_idle_pct = 27;
    run_random_phase(RANDOM_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(RANDOM_ITEMS);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_awaited != 0) @(posedge clk);
    // Quiet period: any stray result transaction shows up as a mismatch here.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_awaited == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
